// ----- rtl/core/trsmd_pkg.sv -----
// ----------------------------------------------------------------------------
// trsmd_pkg
// Shared constants, pipeline types and per-step arithmetic for the matrix
// decomposition pipeline.
// ----------------------------------------------------------------------------
package trsmd_pkg;

	localparam int NUM_ELEM     = 9;
	localparam int NUM_COL      = 3;
	localparam int IN_W         = 32;
	localparam int SQ_STEPS     = 32;
	localparam int DIV_STEPS    = 31;
	localparam int SQ2_STEPS    = 31;
	localparam int CORDIC_STEPS = 23;
	localparam int PIPE_DEPTH   = 2 + SQ_STEPS + DIV_STEPS + 2 + SQ2_STEPS + 1 + CORDIC_STEPS + 1;

	localparam logic signed [26:0] DEG180  = 27'sd11796480;
	localparam logic signed [26:0] DEG90   = 27'sd5898240;
	localparam logic [30:0]        ONE_Q30 = 31'h4000_0000;
	localparam logic [63:0]        ONE_Q60 = 64'h1000_0000_0000_0000;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sqrt_st_t;

	typedef struct packed {
		logic [32:0] r;
		logic [30:0] q;
	} div_st_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [26:0] acc;
	} cordic_st_t;

	typedef struct packed {
		logic             wz;
		logic [8:0]       neg;
		logic [8:0][31:0] mag;
	} sb_a_t;

	typedef struct packed {
		logic             wz;
		logic [8:0]       neg;
		logic [2:0][31:0] len;
	} sb_b_t;

	typedef struct packed {
		logic             wz;
		logic             gim;
		logic [31:0]      s;
		logic [2:0][30:0] scale;
		logic [8:0][31:0] n;
	} sb_c_t;

	typedef struct packed {
		logic             wz;
		logic             gim;
		logic             s_pos;
		logic [2:0][30:0] scale;
	} sb_d_t;

	function automatic sqrt_st_t isqrt_step(sqrt_st_t a, logic [5:0] j);
		logic [63:0] b4;
		logic [64:0] t;
		sqrt_st_t    o;
		b4 = 64'd1 << {j, 1'b0};
		t  = {1'b0, a.r} + {1'b0, b4};
		o  = a;
		if ({1'b0, a.v} >= t) begin
			o.v = a.v - t[63:0];
			o.r = (a.r >> 1) + b4;
		end else begin
			o.r = a.r >> 1;
		end
		return o;
	endfunction

	function automatic div_st_t div_step(div_st_t a, logic [31:0] len);
		logic [32:0] d;
		div_st_t     o;
		d = a.r - {1'b0, len};
		if (a.r >= {1'b0, len}) begin
			o.q = {a.q[29:0], 1'b1};
			o.r = {d[31:0], 1'b0};
		end else begin
			o.q = {a.q[29:0], 1'b0};
			o.r = {a.r[31:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic signed [26:0] atan_deg(logic [4:0] i);
		logic signed [26:0] v;
		case (i)
			5'd0:    v = 27'sd2949120;
			5'd1:    v = 27'sd1740967;
			5'd2:    v = 27'sd919879;
			5'd3:    v = 27'sd466945;
			5'd4:    v = 27'sd234379;
			5'd5:    v = 27'sd117304;
			5'd6:    v = 27'sd58666;
			5'd7:    v = 27'sd29335;
			5'd8:    v = 27'sd14668;
			5'd9:    v = 27'sd7334;
			5'd10:   v = 27'sd3667;
			5'd11:   v = 27'sd1833;
			5'd12:   v = 27'sd917;
			5'd13:   v = 27'sd458;
			5'd14:   v = 27'sd229;
			5'd15:   v = 27'sd115;
			5'd16:   v = 27'sd57;
			5'd17:   v = 27'sd29;
			5'd18:   v = 27'sd14;
			5'd19:   v = 27'sd7;
			5'd20:   v = 27'sd4;
			5'd21:   v = 27'sd2;
			5'd22:   v = 27'sd1;
			default: v = 27'sd0;
		endcase
		return v;
	endfunction

	function automatic cordic_st_t cordic_step(cordic_st_t a, logic [4:0] i);
		cordic_st_t o;
		o = a;
		if (a.y > 0) begin
			o.x   = a.x + (a.y >>> i);
			o.y   = a.y - (a.x >>> i);
			o.acc = a.acc + atan_deg(i);
		end else if (a.y < 0) begin
			o.x   = a.x - (a.y >>> i);
			o.y   = a.y + (a.x >>> i);
			o.acc = a.acc - atan_deg(i);
		end
		return o;
	endfunction

endpackage

// ----- rtl/core/trs_matrix_decompose.sv -----
// ----------------------------------------------------------------------------
// trs_matrix_decompose
// Splits the upper 3x3 of an affine matrix into per-axis scale and Euler
// angles in degrees, one matrix per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
// The input stream carries one matrix per word: nine Q16.16 entries, column
// by column, followed by the bottom-right term. The output stream carries one
// result word per matrix, in input order.
// A matrix passes from acceptance to a valid result word through the squaring
// and summing registers, 32 square-root stages, 31 divider stages, the
// normalization registers, 31 more square-root stages, one setup stage, 23
// CORDIC stages and the output register.
// Throughput is one word per cycle: every stage is a register stage and a new
// word enters whenever the pipeline advances.
// The whole pipeline advances together; it holds when the output register is
// full and the receiver is not ready, and input ready falls in the same cycle.
// No word is lost or repeated across a stall.
// Reset clears only the valid bits, so the output stream is empty afterwards.
// ----------------------------------------------------------------------------
module trs_matrix_decompose (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z, w_term
	input  logic [319:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, zero pad
	output logic [167:0] m_axis_tdata,
	// valid_res, gimbal
	output logic [1:0]   m_axis_tuser
);

	localparam int LAT = trsmd_pkg::PIPE_DEPTH;
	localparam int SQN = trsmd_pkg::SQ_STEPS;
	localparam int DVN = trsmd_pkg::DIV_STEPS;
	localparam int S2N = trsmd_pkg::SQ2_STEPS;
	localparam int CDN = trsmd_pkg::CORDIC_STEPS;

	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv           = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	logic [31:0]         mag_c [trsmd_pkg::NUM_ELEM];
	trsmd_pkg::sb_a_t    sba_s1;
	logic [8:0][62:0]    sq_s1;
	trsmd_pkg::sb_a_t    sba_s2;
	logic [2:0][63:0]    sum_s2;

	always_comb begin
		for (int k = 0; k < trsmd_pkg::NUM_ELEM; k++) begin
			mag_c[k] = s_axis_tdata[32*k+31] ? (32'd0 - s_axis_tdata[32*k +: 32])
				: s_axis_tdata[32*k +: 32];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sba_s1.wz <= (s_axis_tdata[288 +: 32] == 32'd0);
			for (int k = 0; k < trsmd_pkg::NUM_ELEM; k++) begin
				sba_s1.neg[k] <= s_axis_tdata[32*k+31];
				sba_s1.mag[k] <= mag_c[k];
				sq_s1[k]      <= 63'(64'(mag_c[k]) * 64'(mag_c[k]));
			end
			sba_s2 <= sba_s1;
			for (int c = 0; c < trsmd_pkg::NUM_COL; c++) begin
				sum_s2[c] <= 64'(sq_s1[3*c]) + 64'(sq_s1[3*c+1]) + 64'(sq_s1[3*c+2]);
			end
		end
	end

	trsmd_pkg::sqrt_st_t sr_s3  [SQN][trsmd_pkg::NUM_COL];
	trsmd_pkg::sb_a_t    sra_s3 [SQN];

	for (genvar p = 0; p < SQN; p++) begin : g_sqrt
		if (p == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					sra_s3[p] <= sba_s2;
					for (int c = 0; c < trsmd_pkg::NUM_COL; c++) begin
						sr_s3[p][c] <= trsmd_pkg::isqrt_step(
							trsmd_pkg::sqrt_st_t'{v: sum_s2[c], r: 64'd0}, 6'(SQN-1));
					end
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (adv) begin
					sra_s3[p] <= sra_s3[p-1];
					for (int c = 0; c < trsmd_pkg::NUM_COL; c++) begin
						sr_s3[p][c] <= trsmd_pkg::isqrt_step(sr_s3[p-1][c], 6'(SQN-1-p));
					end
				end
			end
		end
	end

	trsmd_pkg::sb_b_t   sbb_c;
	trsmd_pkg::div_st_t dv_s4  [DVN][trsmd_pkg::NUM_ELEM];
	trsmd_pkg::sb_b_t   sbb_s4 [DVN];

	always_comb begin
		sbb_c.wz  = sra_s3[SQN-1].wz;
		sbb_c.neg = sra_s3[SQN-1].neg;
		for (int c = 0; c < trsmd_pkg::NUM_COL; c++) begin
			sbb_c.len[c] = sr_s3[SQN-1][c].r[31:0];
		end
	end

	for (genvar p = 0; p < DVN; p++) begin : g_div
		if (p == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					sbb_s4[p] <= sbb_c;
					for (int k = 0; k < trsmd_pkg::NUM_ELEM; k++) begin
						dv_s4[p][k] <= trsmd_pkg::div_step(
							trsmd_pkg::div_st_t'{r: {1'b0, sra_s3[SQN-1].mag[k]}, q: 31'd0},
							sbb_c.len[k/3]);
					end
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (adv) begin
					sbb_s4[p] <= sbb_s4[p-1];
					for (int k = 0; k < trsmd_pkg::NUM_ELEM; k++) begin
						dv_s4[p][k] <= trsmd_pkg::div_step(dv_s4[p-1][k],
							sbb_s4[p-1].len[k/3]);
					end
				end
			end
		end
	end

	trsmd_pkg::sb_c_t sbc_c;
	trsmd_pkg::sb_c_t sbc_s5;
	trsmd_pkg::sb_c_t sbc_s6;
	logic [61:0]      ssq_s6;
	logic [30:0]      s_abs;

	always_comb begin
		sbc_c.wz = sbb_s4[DVN-1].wz;
		for (int c = 0; c < trsmd_pkg::NUM_COL; c++) begin
			sbc_c.scale[c] = sbb_s4[DVN-1].len[c][31] ? 31'h7FFF_FFFF
				: sbb_s4[DVN-1].len[c][30:0];
		end
		for (int k = 0; k < trsmd_pkg::NUM_ELEM; k++) begin
			if (sbb_s4[DVN-1].len[k/3] == 32'd0) begin
				sbc_c.n[k] = 32'd0;
			end else if (sbb_s4[DVN-1].neg[k]) begin
				sbc_c.n[k] = 32'd0 - {1'b0, dv_s4[DVN-1][k].q};
			end else begin
				sbc_c.n[k] = {1'b0, dv_s4[DVN-1][k].q};
			end
		end
		sbc_c.s   = 32'd0 - sbc_c.n[2];
		sbc_c.gim = (sbb_s4[DVN-1].len[0] != 32'd0) &&
			(dv_s4[DVN-1][2].q == trsmd_pkg::ONE_Q30);
		s_abs = sbc_s5.s[31] ? 31'(32'd0 - sbc_s5.s) : sbc_s5.s[30:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sbc_s5 <= sbc_c;
			sbc_s6 <= sbc_s5;
			ssq_s6 <= 62'(64'(s_abs) * 64'(s_abs));
		end
	end

	trsmd_pkg::sqrt_st_t sr2_s7  [S2N];
	trsmd_pkg::sb_c_t    sbc_s7  [S2N];

	for (genvar p = 0; p < S2N; p++) begin : g_sqrt2
		if (p == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					sbc_s7[p] <= sbc_s6;
					sr2_s7[p] <= trsmd_pkg::isqrt_step(trsmd_pkg::sqrt_st_t'{
						v: trsmd_pkg::ONE_Q60 - 64'(ssq_s6), r: 64'd0}, 6'(S2N-1));
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (adv) begin
					sbc_s7[p] <= sbc_s7[p-1];
					sr2_s7[p] <= trsmd_pkg::isqrt_step(sr2_s7[p-1], 6'(S2N-1-p));
				end
			end
		end
	end

	logic signed [33:0]     py_c   [3];
	logic signed [33:0]     px_c   [3];
	trsmd_pkg::cordic_st_t  cd_c   [3];
	logic signed [26:0]     base_c [3];
	trsmd_pkg::sb_d_t       sbd_c;
	trsmd_pkg::cordic_st_t  cd_s8  [3];
	logic signed [26:0]     base_s8 [3];
	trsmd_pkg::sb_d_t       sbd_s8;

	always_comb begin
		if (sbc_s7[S2N-1].gim) begin
			py_c[0] = 34'sd0 - 34'(signed'(sbc_s7[S2N-1].n[6]));
			px_c[0] = 34'(signed'(sbc_s7[S2N-1].n[4]));
		end else begin
			py_c[0] = 34'(signed'(sbc_s7[S2N-1].n[5]));
			px_c[0] = 34'(signed'(sbc_s7[S2N-1].n[8]));
		end
		py_c[1] = 34'(signed'(sbc_s7[S2N-1].s));
		px_c[1] = signed'({3'b000, sr2_s7[S2N-1].r[30:0]});
		py_c[2] = 34'(signed'(sbc_s7[S2N-1].n[1]));
		px_c[2] = 34'(signed'(sbc_s7[S2N-1].n[0]));
		for (int u = 0; u < 3; u++) begin
			cd_c[u].acc = 27'sd0;
			if (px_c[u] < 0) begin
				cd_c[u].x = -px_c[u];
				cd_c[u].y = -py_c[u];
				base_c[u] = (py_c[u] >= 0) ? trsmd_pkg::DEG180 : -trsmd_pkg::DEG180;
			end else begin
				cd_c[u].x = px_c[u];
				cd_c[u].y = py_c[u];
				base_c[u] = 27'sd0;
			end
		end
		sbd_c.wz    = sbc_s7[S2N-1].wz;
		sbd_c.gim   = sbc_s7[S2N-1].gim;
		sbd_c.s_pos = !sbc_s7[S2N-1].s[31];
		sbd_c.scale = sbc_s7[S2N-1].scale;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cd_s8   <= cd_c;
			base_s8 <= base_c;
			sbd_s8  <= sbd_c;
		end
	end

	trsmd_pkg::cordic_st_t cd_s9   [CDN][3];
	logic signed [26:0]    base_s9 [CDN][3];
	trsmd_pkg::sb_d_t      sbd_s9  [CDN];

	for (genvar p = 0; p < CDN; p++) begin : g_cordic
		if (p == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					sbd_s9[p]  <= sbd_s8;
					base_s9[p] <= base_s8;
					for (int u = 0; u < 3; u++) begin
						cd_s9[p][u] <= trsmd_pkg::cordic_step(cd_s8[u], 5'(p));
					end
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (adv) begin
					sbd_s9[p]  <= sbd_s9[p-1];
					base_s9[p] <= base_s9[p-1];
					for (int u = 0; u < 3; u++) begin
						cd_s9[p][u] <= trsmd_pkg::cordic_step(cd_s9[p-1][u], 5'(p));
					end
				end
			end
		end
	end

	logic signed [26:0] ang_c [3];
	logic signed [26:0] ax_c;
	logic signed [26:0] ay_c;
	logic signed [26:0] az_c;
	logic [166:0]       data_c;
	logic [1:0]         user_c;
	logic [166:0]       data_s10;
	logic [1:0]         user_s10;

	always_comb begin
		for (int u = 0; u < 3; u++) begin
			ang_c[u] = base_s9[CDN-1][u] + cd_s9[CDN-1][u].acc;
			if (ang_c[u] > trsmd_pkg::DEG180) begin
				ang_c[u] = trsmd_pkg::DEG180;
			end else if (ang_c[u] < -trsmd_pkg::DEG180) begin
				ang_c[u] = -trsmd_pkg::DEG180;
			end
		end
		ax_c = ang_c[0];
		if (sbd_s9[CDN-1].gim) begin
			ay_c = sbd_s9[CDN-1].s_pos ? trsmd_pkg::DEG90 : -trsmd_pkg::DEG90;
			az_c = 27'sd0;
		end else begin
			ay_c = ang_c[1];
			if (ay_c > trsmd_pkg::DEG90) begin
				ay_c = trsmd_pkg::DEG90;
			end else if (ay_c < -trsmd_pkg::DEG90) begin
				ay_c = -trsmd_pkg::DEG90;
			end
			az_c = ang_c[2];
		end
		if (sbd_s9[CDN-1].wz) begin
			data_c = '0;
			user_c = 2'b00;
		end else begin
			data_c = {az_c[24:0], ay_c[23:0], ax_c[24:0], sbd_s9[CDN-1].scale[2],
				sbd_s9[CDN-1].scale[1], sbd_s9[CDN-1].scale[0]};
			user_c = {sbd_s9[CDN-1].gim, 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s10 <= data_c;
			user_s10 <= user_c;
		end
	end

	assign m_axis_tdata = {1'b0, data_s10};
	assign m_axis_tuser = user_s10;

endmodule

// ----- bench/trsmd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trsmd_checker
// Watches both streams of the matrix decomposition block, works out the
// expected result word of every accepted matrix and compares it field by
// field with the result words in order.
// ----------------------------------------------------------------------------
module trsmd_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [319:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [167:0] m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	output int           errors,
	output int           pending,
	output int           n_gimbal,
	output int           n_reject,
	output int           n_results
);

	typedef struct packed {
		logic [167:0] data;
		logic [1:0]   user;
	} result_t;

	localparam longint ONE   = 64'sd1 << 30;
	localparam longint D180  = 64'sd11796480;
	localparam longint D90   = 64'sd5898240;
	localparam longint ATAN_TAB [0:22] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1
	};

	result_t expected_q[$];

	function automatic logic [63:0] sqrt_floor(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint angle_of(longint y, longint x);
		longint base;
		longint acc;
		longint nx;
		base = 0;
		acc  = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = (y <= 0) ? D180 : -D180;
		end
		for (int i = 0; i < 23; i++) begin
			if (y > 0) begin
				nx  = x + (y >>> i);
				y   = y - (x >>> i);
				x   = nx;
				acc = acc + ATAN_TAB[i];
			end else if (y < 0) begin
				nx  = x - (y >>> i);
				y   = y + (x >>> i);
				x   = nx;
				acc = acc - ATAN_TAB[i];
			end
		end
		acc = base + acc;
		if (acc > D180)
			acc = D180;
		if (acc < -D180)
			acc = -D180;
		return acc;
	endfunction

	function automatic logic [30:0] column_norm(input longint a, input longint b,
			input longint c, output longint na, output longint nb, output longint nc);
		logic [63:0] len;
		logic [63:0] u [3];
		longint      v [3];
		v[0] = a;
		v[1] = b;
		v[2] = c;
		len = sqrt_floor(magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b)
			+ magnitude(c) * magnitude(c));
		for (int k = 0; k < 3; k++) begin
			u[k] = 0;
			if (len != 0) begin
				u[k] = (magnitude(v[k]) << 30) / len;
				if (u[k] > ONE)
					u[k] = ONE;
			end
		end
		na = a < 0 ? -longint'(u[0]) : longint'(u[0]);
		nb = b < 0 ? -longint'(u[1]) : longint'(u[1]);
		nc = c < 0 ? -longint'(u[2]) : longint'(u[2]);
		return len > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : len[30:0];
	endfunction

	function automatic result_t decompose(logic [319:0] word);
		result_t     res;
		longint      e [10];
		longint      n [9];
		logic [30:0] sc [3];
		longint      s;
		longint      ax;
		longint      ay;
		longint      az;
		logic        gim;
		res = '0;
		for (int i = 0; i < 10; i++)
			e[i] = longint'(signed'(word[32*i +: 32]));
		if (e[9] == 0)
			return res;
		for (int c = 0; c < 3; c++)
			sc[c] = column_norm(e[3*c], e[3*c+1], e[3*c+2], n[3*c], n[3*c+1], n[3*c+2]);
		s = -n[2];
		gim = (s == ONE || s == -ONE);
		if (gim) begin
			ay = s > 0 ? D90 : -D90;
			ax = angle_of(-n[6], n[4]);
			az = 0;
		end else begin
			ay = angle_of(s, longint'(sqrt_floor(ONE * ONE - s * s)));
			if (ay > D90)
				ay = D90;
			if (ay < -D90)
				ay = -D90;
			ax = angle_of(n[5], n[8]);
			az = angle_of(n[1], n[0]);
		end
		res.data[30:0]    = sc[0];
		res.data[61:31]   = sc[1];
		res.data[92:62]   = sc[2];
		res.data[117:93]  = ax[24:0];
		res.data[141:118] = ay[23:0];
		res.data[166:142] = az[24:0];
		res.user          = {gim, 1'b1};
		return res;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			expected_q.delete();
			errors = 0;
			n_gimbal  <= 0;
			n_reject  <= 0;
			n_results <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(decompose(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				n_results <= n_results + 1;
				if (expected_q.size() == 0) begin
					$error("result word with no matrix outstanding");
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.user[1])
						n_gimbal <= n_gimbal + 1;
					if (!exp_r.user[0])
						n_reject <= n_reject + 1;
					check_field("valid_res", exp_r.user[0], m_axis_tuser[0]);
					check_field("gimbal", exp_r.user[1], m_axis_tuser[1]);
					check_field("scale_x", exp_r.data[30:0], m_axis_tdata[30:0]);
					check_field("scale_y", exp_r.data[61:31], m_axis_tdata[61:31]);
					check_field("scale_z", exp_r.data[92:62], m_axis_tdata[92:62]);
					check_field("angle_x", exp_r.data[117:93], m_axis_tdata[117:93]);
					check_field("angle_y", exp_r.data[141:118], m_axis_tdata[141:118]);
					check_field("angle_z", exp_r.data[166:142], m_axis_tdata[166:142]);
					check_field("pad", exp_r.data[167], m_axis_tdata[167]);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ----- bench/tb_trs_matrix_decompose.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trs_matrix_decompose
// Drives matrices into the decomposition block: a directed set of corner
// cases, then random matrices of several shapes under varying back-pressure.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_trs_matrix_decompose;

	localparam int RANDOM_WORDS = 880;
	localparam int IDLE_LIMIT   = 5000;
	localparam int HOLD_CYCLES  = 600;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [319:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [167:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	int errors;
	int pending;
	int n_gimbal;
	int n_reject;
	int n_results;
	int phase;
	int send_idle;
	int recv_idle;
	int idle_cycles;
	bit held;

	trs_matrix_decompose dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	trsmd_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.errors       (errors),
		.pending      (pending),
		.n_gimbal     (n_gimbal),
		.n_reject     (n_reject),
		.n_results    (n_results)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [319:0] matrix(logic [31:0] a0, logic [31:0] a1,
			logic [31:0] a2, logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
			logic [31:0] c0, logic [31:0] c1, logic [31:0] c2, logic [31:0] w);
		return {w, c2, c1, c0, b2, b1, b0, a2, a1, a0};
	endfunction

	function automatic logic [31:0] rand_entry(int shape);
		logic [31:0] v;
		case (shape)
			0: v = $urandom();
			1: v = $urandom_range(131072);
			2: v = $urandom() >> $urandom_range(31);
			default: v = $urandom_range(3) == 0 ? 32'd0 : $urandom_range(65536);
		endcase
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	function automatic logic [319:0] rand_matrix();
		logic [31:0] e [10];
		int          shape;
		shape = $urandom_range(3);
		for (int i = 0; i < 9; i++)
			e[i] = rand_entry(shape);
		if ($urandom_range(9) == 0) begin
			e[0] = 0;
			e[1] = 0;
			e[2] = rand_entry(shape);
		end
		if ($urandom_range(19) == 0)
			e[3 * $urandom_range(2) + $urandom_range(2)] = 0;
		e[9] = $urandom_range(19) == 0 ? 32'd0 : $urandom();
		if (e[9] == 0 && $urandom_range(1) == 0)
			e[9] = 32'h0001_0000;
		return matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8], e[9]);
	endfunction

	task automatic send_word(logic [319:0] word);
		bit rdy;
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase == 2 && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] neg_one;
		neg_one       = -32'sd65536;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		phase         = 0;
		send_idle     = 7;
		recv_idle     = 71;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity, rejection, zero columns, saturation and the gimbal branch.
		send_word(matrix(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000));
		send_word(matrix(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
		send_word(matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
		send_word(matrix(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
		send_word(matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1));
		send_word(matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF));
		send_word(matrix(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000,
			32'hFFFF_FFFF));
		send_word(matrix(0, 0, 32'h10000, 0, 32'h10000, 0, neg_one, 0, 0, 1));
		send_word(matrix(0, 0, neg_one, 0, 32'h10000, 0, 32'h10000, 0, 0, 1));
		send_word(matrix(0, 0, 32'h30000, 0, 0, 0, 0, 0, 0, 1));
		send_word(matrix(neg_one, 0, 0, 0, neg_one, 0, 0, 0, neg_one, 1));
		send_word(matrix(neg_one, 32'h10000, 0, 0, 0, 32'h10000, 0, 0, neg_one, 1));
		send_word(matrix(neg_one, neg_one, 0, 0, 0, neg_one, 0, 0, 0, 1));
		send_word(matrix(neg_one, 0, 32'h8000, 0, 32'h10000, 0, 0, 0, 32'h10000, 1));
		send_word(matrix(32'hB505, 32'hB505, 0, 0, 32'hB505, 32'hB505, 32'hB505, 0,
			32'hB505, 1));
		send_word(matrix(1, 0, 0, 0, 1, 0, 0, 0, 1, 1));
		send_word(matrix(32'h10000, 0, 32'h1, 0, 32'h10000, 0, 0, 0, 32'h10000, 1));
		send_word(matrix(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA));
		send_word(matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555));

		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 300) begin
				send_idle = 71;
				recv_idle = 7;
				phase     = 1;
			end else if (i == 600) begin
				send_idle = 0;
				recv_idle = 0;
				phase     = 2;
			end
			send_word(rand_matrix());
		end
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (130) @(posedge clk);
		$display("Ran %0d result words: %0d rejected, %0d in the gimbal branch,",
			n_results, n_reject, n_gimbal);
		$display("under sender, receiver and no back-pressure plus one long output stall.");
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- trs_matrix_decompose.f -----
rtl/core/trsmd_pkg.sv
rtl/core/trs_matrix_decompose.sv
bench/trsmd_checker.sv
bench/tb_trs_matrix_decompose.sv
